/* sv/cau_pkg.sv */
package cau_pkg;

  localparam int OperandWidthDef = 16;
  localparam int FractionBitsDef = 16;
  localparam int OutWidth        = 49;
  localparam int KindWidth       = 2;
  localparam int QueueDepth      = 4;
  localparam int OutDataWidth    = ((2 * OutWidth + 7) / 8) * 8;

  typedef enum logic [KindWidth-1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } cau_kind_e;

  // Classification that the front end attaches to every operand set.
  typedef struct packed {
    cau_kind_e kind;
    logic      b_zero;
  } cau_ctrl_t;

endpackage

/* sv/cau_front.sv */
module cau_front import cau_pkg::*; #(
  parameter int OperandWidth = OperandWidthDef,
  parameter int InDataWidth  = ((4 * OperandWidth + 7) / 8) * 8
) (
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [InDataWidth-1:0]    s_axis_tdata_i,
  input  logic [KindWidth-1:0]      s_axis_tuser_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output cau_ctrl_t                 ctrl_o,
  output logic [4*OperandWidth-1:0] ops_o
);

  logic [OperandWidth-1:0] b_real;
  logic [OperandWidth-1:0] b_imag;

  assign b_real = s_axis_tdata_i[3*OperandWidth-1:2*OperandWidth];
  assign b_imag = s_axis_tdata_i[4*OperandWidth-1:3*OperandWidth];

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  // A zero divisor is spotted here so the back end only has to carry a flag.
  assign ctrl_o.kind   = cau_kind_e'(s_axis_tuser_i);
  assign ctrl_o.b_zero = (b_real == '0) && (b_imag == '0);
  assign ops_o         = s_axis_tdata_i[4*OperandWidth-1:0];

endmodule

/* sv/cau_queue.sv */
module cau_queue import cau_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

endmodule

/* sv/cau_back.sv */
module cau_back import cau_pkg::*; #(
  parameter int OperandWidth = OperandWidthDef,
  parameter int FractionBits = FractionBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  output logic                      pop_o,
  input  cau_ctrl_t                 ctrl_i,
  input  logic [4*OperandWidth-1:0] ops_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [OutWidth-1:0]       real_o,
  output logic [OutWidth-1:0]       imag_o,
  output logic                      flag_o
);

  localparam int W   = OperandWidth;
  localparam int F   = FractionBits;
  localparam int PW  = 2 * W;
  localparam int VW  = 2 * W + 1;
  localparam int DW  = 2 * W;
  localparam int QB  = 2 * W + F;
  localparam int XW  = VW + F + OutWidth;
  localparam int QXW = QB + OutWidth + 1;

  localparam logic signed [XW-1:0] XMax = (XW'(1) <<< (OutWidth - 1)) - XW'(1);
  localparam logic signed [XW-1:0] XMin = -(XW'(1) <<< (OutWidth - 1));

  function automatic logic [OutWidth-1:0] sat_fix(input logic signed [VW-1:0] v);
    logic signed [XW-1:0] x;
    x = XW'(v) <<< F;
    if (x > XMax) begin
      x = XMax;
    end else if (x < XMin) begin
      x = XMin;
    end
    return x[OutWidth-1:0];
  endfunction

  function automatic logic [OutWidth-1:0] sat_quo(input logic [QB-1:0] q, input logic neg);
    logic [QXW-1:0] qx;
    logic [QXW-1:0] lim;
    qx  = QXW'(q);
    lim = neg ? (QXW'(1) << (OutWidth - 1)) : ((QXW'(1) << (OutWidth - 1)) - QXW'(1));
    if (qx > lim) begin
      qx = lim;
    end
    if (neg) begin
      qx = -qx;
    end
    return qx[OutWidth-1:0];
  endfunction

  logic adv;
  logic signed [W-1:0] ar, ai, br, bi;

  // Product stage.
  logic                 p1_v_q;
  cau_kind_e            p1_kind_q;
  logic                 p1_bz_q;
  logic signed [PW-1:0] p1_rr_q, p1_ii_q, p1_ir_q, p1_ri_q, p1_br2_q, p1_bi2_q;
  logic signed [VW-1:0] p1_sre_q, p1_sim_q;
  logic signed [VW-1:0] sum_re, sum_im;

  // Divider stages; entry 0 is loaded from the product stage.
  logic                st_v_q    [QB+1];
  logic                st_div_q  [QB+1];
  logic                st_bz_q   [QB+1];
  logic                st_nre_q  [QB+1];
  logic                st_nim_q  [QB+1];
  logic [DW-1:0]       st_den_q  [QB+1];
  logic [DW-1:0]       st_rre_q  [QB+1];
  logic [DW-1:0]       st_rim_q  [QB+1];
  logic [QB-1:0]       st_qre_q  [QB+1];
  logic [QB-1:0]       st_qim_q  [QB+1];
  logic [OutWidth-1:0] st_fre_q  [QB+1];
  logic [OutWidth-1:0] st_fim_q  [QB+1];

  logic signed [VW-1:0] mul_re, mul_im, num_re, num_im, v_re, v_im;
  logic [DW-1:0]        den, mag_re, mag_im;

  logic                m_valid_q;
  logic [OutWidth-1:0] out_re_q, out_im_q;
  logic                out_flag_q;

  assign adv   = !m_valid_q || m_axis_tready_i;
  assign pop_o = adv && !empty_i;

  assign ar = ops_i[W-1:0];
  assign ai = ops_i[2*W-1:W];
  assign br = ops_i[3*W-1:2*W];
  assign bi = ops_i[4*W-1:3*W];

  assign sum_re = (ctrl_i.kind == KIND_SUB) ? (VW'(ar) - VW'(br)) : (VW'(ar) + VW'(br));
  assign sum_im = (ctrl_i.kind == KIND_SUB) ? (VW'(ai) - VW'(bi)) : (VW'(ai) + VW'(bi));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_kind_q <= ctrl_i.kind;
      p1_bz_q   <= ctrl_i.b_zero;
      p1_rr_q   <= ar * br;
      p1_ii_q   <= ai * bi;
      p1_ir_q   <= ai * br;
      p1_ri_q   <= ar * bi;
      p1_br2_q  <= br * br;
      p1_bi2_q  <= bi * bi;
      p1_sre_q  <= sum_re;
      p1_sim_q  <= sum_im;
    end
  end

  // Numerators come from a times the conjugate of b; the divisor is |b|^2.
  always_comb begin
    mul_re = VW'(p1_rr_q) - VW'(p1_ii_q);
    mul_im = VW'(p1_ir_q) + VW'(p1_ri_q);
    num_re = VW'(p1_rr_q) + VW'(p1_ii_q);
    num_im = VW'(p1_ir_q) - VW'(p1_ri_q);
    den    = DW'($unsigned(p1_br2_q)) + DW'($unsigned(p1_bi2_q));
    v_re   = (p1_kind_q == KIND_MUL) ? mul_re : p1_sre_q;
    v_im   = (p1_kind_q == KIND_MUL) ? mul_im : p1_sim_q;
    mag_re = DW'(num_re[VW-1] ? -num_re : num_re);
    mag_im = DW'(num_im[VW-1] ? -num_im : num_im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q[0] <= 1'b0;
    end else if (adv) begin
      st_v_q[0] <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_div_q[0] <= (p1_kind_q == KIND_DIV);
      st_bz_q[0]  <= p1_bz_q;
      st_nre_q[0] <= num_re[VW-1];
      st_nim_q[0] <= num_im[VW-1];
      st_den_q[0] <= den;
      st_rre_q[0] <= '0;
      st_rim_q[0] <= '0;
      st_qre_q[0] <= QB'(mag_re) << F;
      st_qim_q[0] <= QB'(mag_im) << F;
      st_fre_q[0] <= sat_fix(v_re);
      st_fim_q[0] <= sat_fix(v_im);
    end
  end

  // One restoring quotient bit per stage; the quotient shifts in where the
  // dividend bits shift out.
  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [DW:0]   r2_re, r2_im;
    logic          ge_re, ge_im;
    logic [DW-1:0] rn_re, rn_im;

    always_comb begin
      r2_re = {st_rre_q[s], st_qre_q[s][QB-1]};
      r2_im = {st_rim_q[s], st_qim_q[s][QB-1]};
      ge_re = r2_re >= {1'b0, st_den_q[s]};
      ge_im = r2_im >= {1'b0, st_den_q[s]};
      rn_re = ge_re ? DW'(r2_re - {1'b0, st_den_q[s]}) : r2_re[DW-1:0];
      rn_im = ge_im ? DW'(r2_im - {1'b0, st_den_q[s]}) : r2_im[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[s+1] <= 1'b0;
      end else if (adv) begin
        st_v_q[s+1] <= st_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_div_q[s+1] <= st_div_q[s];
        st_bz_q[s+1]  <= st_bz_q[s];
        st_nre_q[s+1] <= st_nre_q[s];
        st_nim_q[s+1] <= st_nim_q[s];
        st_den_q[s+1] <= st_den_q[s];
        st_rre_q[s+1] <= rn_re;
        st_rim_q[s+1] <= rn_im;
        st_qre_q[s+1] <= {st_qre_q[s][QB-2:0], ge_re};
        st_qim_q[s+1] <= {st_qim_q[s][QB-2:0], ge_im};
        st_fre_q[s+1] <= st_fre_q[s];
        st_fim_q[s+1] <= st_fim_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= st_v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!st_div_q[QB]) begin
        out_re_q <= st_fre_q[QB];
        out_im_q <= st_fim_q[QB];
      end else if (st_bz_q[QB]) begin
        out_re_q <= '0;
        out_im_q <= '0;
      end else begin
        out_re_q <= sat_quo(st_qre_q[QB], st_nre_q[QB]);
        out_im_q <= sat_quo(st_qim_q[QB], st_nim_q[QB]);
      end
      out_flag_q <= st_div_q[QB] && st_bz_q[QB];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign real_o          = out_re_q;
  assign imag_o          = out_im_q;
  assign flag_o          = out_flag_q;

  a_flag_zero_parts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_flag_q |-> (out_re_q == '0) && (out_im_q == '0))
    else $error("zero divisor result carries nonzero parts");

  a_no_pop_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready_i |-> !pop_o)
    else $error("queue popped while the output is stalled");

endmodule

/* sv/complex_arithmetic_unit.sv */
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata tuser        operands and operation code
// m_axis    out        tvalid tready tdata tuser        result parts and zero-divisor flag
//
// One transaction is accepted per cycle while the queue is not full, and
// one result leaves per cycle while the output is not stalled. The
// divider retires one quotient bit per pipeline stage.
// Reset is asynchronous and active low; it empties the queue and the pipeline.
// A stalled output freezes the whole back end while the front end keeps
// filling the queue until it is full, then drops s_axis_tready_o.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int OperandWidth = OperandWidthDef,
  parameter int FractionBits = FractionBitsDef,
  parameter int InDataWidth  = ((4 * OperandWidth + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // a_real, a_imag, b_real, b_imag (OperandWidth bits each, signed), zero fill
  input  logic [InDataWidth-1:0]  s_axis_tdata_i,
  // kind: 0 add, 1 subtract, 2 multiply, 3 divide
  input  logic [KindWidth-1:0]    s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // real_part (49 bits), imag_part (49 bits), both signed fixed point, zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata_o,
  // div_by_zero
  output logic                    m_axis_tuser_o
);

  localparam int OpsW = 4 * OperandWidth;
  localparam int QW   = $bits(cau_ctrl_t) + OpsW;

  logic                push, pop, q_full, q_empty;
  cau_ctrl_t           ctrl_in, ctrl_out;
  logic [OpsW-1:0]     ops_in, ops_out;
  logic [QW-1:0]       q_out;
  logic [OutWidth-1:0] res_re, res_im;

  // The front end only classifies the transaction; all arithmetic happens
  // behind the queue.
  cau_front #(
    .OperandWidth (OperandWidth),
    .InDataWidth  (InDataWidth)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .ctrl_o          (ctrl_in),
    .ops_o           (ops_in)
  );

  cau_queue #(
    .Width (QW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({ctrl_in, ops_in}),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign ctrl_out = q_out[QW-1:OpsW];
  assign ops_out  = q_out[OpsW-1:0];

  // The back end runs products, then the bit-per-stage divider, then the
  // output register that decouples it from the downstream consumer.
  cau_back #(
    .OperandWidth (OperandWidth),
    .FractionBits (FractionBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .ctrl_i          (ctrl_out),
    .ops_i           (ops_out),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .real_o          (res_re),
    .imag_o          (res_im),
    .flag_o          (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {(OutDataWidth - 2 * OutWidth)'(0), res_im, res_re};

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cau_pkg::*;

  localparam int Ow = OperandWidthDef;
  localparam int Fb = FractionBitsDef;
  localparam int InW = ((4 * Ow + 7) / 8) * 8;
  localparam int Latency = 2 * Ow + Fb + 4;

  typedef struct packed {
    logic [OutWidth-1:0] re;
    logic [OutWidth-1:0] im;
    logic                dz;
  } cplx_res_t;

  // Fixed-point scaling of an integer, saturated to the output range.
  function automatic logic signed [OutWidth-1:0] scale_sat(longint v);
    longint hi, lo;
    hi = ((longint'(1) <<< (OutWidth - 1)) - 1) >>> Fb;
    lo = -((longint'(1) <<< (OutWidth - 1)) >>> Fb);
    if (v > hi) return {1'b0, {(OutWidth-1){1'b1}}};
    if (v < lo) return {1'b1, {(OutWidth-1){1'b0}}};
    return OutWidth'(v <<< Fb);
  endfunction

  // num * 2^Fb / den, truncated toward zero; den is positive.
  function automatic logic signed [OutWidth-1:0] quot_fixed(longint num, longint den);
    longint unsigned mag, q, r, d, cap;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    d = den;
    q = mag / d;
    r = mag % d;
    cap = 64'd1 << OutWidth;
    for (int i = 0; i < Fb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
      if (q > cap) q = cap;
    end
    if (neg) begin
      if (q > (64'd1 << (OutWidth - 1))) q = 64'd1 << (OutWidth - 1);
      return OutWidth'(-longint'(q));
    end
    if (q > ((64'd1 << (OutWidth - 1)) - 1)) q = (64'd1 << (OutWidth - 1)) - 1;
    return OutWidth'(q);
  endfunction

  function automatic cplx_res_t predict_cplx(cau_kind_e k, logic [InW-1:0] d);
    longint ar, ai, br, bi, den;
    cplx_res_t r;
    ar = longint'($signed(d[0*Ow +: Ow]));
    ai = longint'($signed(d[1*Ow +: Ow]));
    br = longint'($signed(d[2*Ow +: Ow]));
    bi = longint'($signed(d[3*Ow +: Ow]));
    r = '0;
    case (k)
      KIND_ADD: begin
        r.re = scale_sat(ar + br);
        r.im = scale_sat(ai + bi);
      end
      KIND_SUB: begin
        r.re = scale_sat(ar - br);
        r.im = scale_sat(ai - bi);
      end
      KIND_MUL: begin
        r.re = scale_sat(ar * br - ai * bi);
        r.im = scale_sat(ai * br + ar * bi);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = quot_fixed(ar * br + ai * bi, den);
          r.im = quot_fixed(ai * br - ar * bi, den);
        end
      end
    endcase
    return r;
  endfunction

  class cplx_scoreboard;
    cplx_res_t pending[$];
    int errors;
    int shown;

    function void note_operands(cau_kind_e k, logic [InW-1:0] d);
      pending.push_back(predict_cplx(k, d));
    endfunction

    function void check_result(logic [OutWidth-1:0] re, logic [OutWidth-1:0] im,
                               logic dz);
      cplx_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result re=%h im=%h dz=%b", re, im, dz);
        end
        return;
      end
      e = pending.pop_front();
      if (e.re !== re || e.im !== im || e.dz !== dz) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected re=%h im=%h dz=%b, got re=%h im=%h dz=%b",
                   e.re, e.im, e.dz, re, im, dz);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InW-1:0] s_tdata = '0;
  logic [KindWidth-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic m_tuser;

  int send_idle_pct;
  int recv_idle_pct;

  cplx_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  complex_arithmetic_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Receiver: random stall, checks each accepted result transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata[0 +: OutWidth], m_tdata[OutWidth +: OutWidth], m_tuser);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Presents one operand set and holds it until accepted. Idle gaps are
  // inserted before the item so valid never drops and rises in one step.
  task automatic send_operands(cau_kind_e k, logic [Ow-1:0] ar, logic [Ow-1:0] ai,
                               logic [Ow-1:0] br, logic [Ow-1:0] bi);
    logic [InW-1:0] d;
    d = '0;
    d[0*Ow +: Ow] = ar;
    d[1*Ow +: Ow] = ai;
    d[2*Ow +: Ow] = br;
    d[3*Ow +: Ow] = bi;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= k;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_operands(k, d);
  endtask

  function automatic logic [Ow-1:0] rand_operand();
    case ($urandom_range(5))
      0: return {1'b1, {(Ow-1){1'b0}}};
      1: return {1'b0, {(Ow-1){1'b1}}};
      2: return Ow'($urandom_range(7)) - Ow'(3);
      default: return Ow'($urandom);
    endcase
  endfunction

  task automatic random_batch(int n);
    logic [Ow-1:0] br, bi;
    for (int i = 0; i < n; i++) begin
      br = rand_operand();
      bi = rand_operand();
      // A zero divisor now and then, so the flag keeps being exercised.
      if ($urandom_range(15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_operands(cau_kind_e'($urandom_range(3)), rand_operand(), rand_operand(),
                    br, bi);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  localparam logic [Ow-1:0] MinV = {1'b1, {(Ow-1){1'b0}}};
  localparam logic [Ow-1:0] MaxV = {1'b0, {(Ow-1){1'b1}}};
  localparam logic [Ow-1:0] NegOne = '1;

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation at the operand extremes, plus zero divisors.
    for (int k = 0; k < 4; k++) begin
      send_operands(cau_kind_e'(k), MaxV, MinV, MinV, MaxV);
      send_operands(cau_kind_e'(k), MinV, MinV, MinV, MinV);
      send_operands(cau_kind_e'(k), MaxV, MaxV, NegOne, '0);
      send_operands(cau_kind_e'(k), '0, NegOne, '0, '0);
    end
    send_operands(KIND_DIV, MaxV, MinV, '0, '0);
    send_operands(KIND_DIV, 16'd1, '0, 16'd3, '0);
    send_operands(KIND_DIV, NegOne, '0, 16'd3, '0);
    send_operands(KIND_DIV, 16'd7, 16'd5, MaxV, 16'd1);

    // The sender holds back until the pipeline has emptied.
    drain_results();

    send_idle_pct = 23;
    recv_idle_pct = 53;
    random_batch(200);
    send_idle_pct = 53;
    recv_idle_pct = 23;
    random_batch(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_batch(200);

    drain_results();
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* complex_arithmetic_unit.f */
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_queue.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
test/tb.sv
